/* rtl/core/lbmsi_pkg.sv */
package lbmsi_pkg;

  // Default and fixed dimensions
  localparam int MAX_EXTENT_DEF = 256;
  localparam int NUM_DIRECTIONS = 15;

  localparam int COORD_W    = 8;
  localparam int SIZE_W     = 9;
  localparam int RANK_W     = 24;
  localparam int CPR_W      = 25;
  localparam int BASE_W     = RANK_W + CPR_W;
  localparam int YZ_W       = 2 * SIZE_W;
  localparam int GIDX_W     = 3 * SIZE_W;
  localparam int DIR_W      = 4;
  localparam int SRC_W      = 28;
  localparam int TGT_W      = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(64);
  localparam logic [CPR_W-1:0]  CPR_RST  = CPR_W'(262144);
  localparam logic [DIR_W-1:0]  DIR_LAST = DIR_W'(NUM_DIRECTIONS - 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z,
    REG_WALLS,
    REG_RANK,
    REG_CPR
  } cfg_reg_t;

  // One velocity component
  typedef enum logic [1:0] {
    STEP_ZERO,
    STEP_UP,
    STEP_DOWN
  } step_t;

  // D3Q15 velocity set
  localparam step_t VEL_X [NUM_DIRECTIONS] = '{
    STEP_ZERO, STEP_DOWN, STEP_UP, STEP_ZERO, STEP_ZERO, STEP_ZERO, STEP_ZERO, STEP_UP,
    STEP_DOWN, STEP_DOWN, STEP_UP, STEP_UP, STEP_DOWN, STEP_DOWN, STEP_UP};
  localparam step_t VEL_Y [NUM_DIRECTIONS] = '{
    STEP_ZERO, STEP_ZERO, STEP_ZERO, STEP_DOWN, STEP_UP, STEP_ZERO, STEP_ZERO, STEP_UP,
    STEP_UP, STEP_DOWN, STEP_DOWN, STEP_UP, STEP_UP, STEP_DOWN, STEP_DOWN};
  localparam step_t VEL_Z [NUM_DIRECTIONS] = '{
    STEP_ZERO, STEP_ZERO, STEP_ZERO, STEP_ZERO, STEP_ZERO, STEP_DOWN, STEP_UP, STEP_UP,
    STEP_UP, STEP_UP, STEP_UP, STEP_DOWN, STEP_DOWN, STEP_DOWN, STEP_DOWN};
  localparam logic [DIR_W-1:0] OPPOSITE [NUM_DIRECTIONS] = '{
    4'd0, 4'd2, 4'd1, 4'd4, 4'd3, 4'd6, 4'd5, 4'd13,
    4'd14, 4'd11, 4'd12, 4'd9, 4'd10, 4'd7, 4'd8};

  // Live configuration (sizes already clamped to the maximum extent)
  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
    logic              walls;
    logic [RANK_W-1:0] rank;
    logic [CPR_W-1:0]  cpr;
  } cfg_t;

  // Owned cell handed to the direction sequencer
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [GIDX_W-1:0]  gidx;
    logic [TGT_W-1:0]   base_lo;
  } cell_req_t;

  // One direction of a cell handed to the neighbour pipeline
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [GIDX_W-1:0]  gidx;
    logic [TGT_W-1:0]   base_lo;
    logic [DIR_W-1:0]   dir;
    logic               last;
  } dir_req_t;

endpackage

/* rtl/core/lbmsi_cell_if.sv */
interface lbmsi_cell_if;
  import lbmsi_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic [COORD_W-1:0] cell_z;

  modport source (output valid, output cell_x, output cell_y, output cell_z, input ready);
  modport sink (input valid, input cell_x, input cell_y, input cell_z, output ready);

endinterface

/* rtl/core/lbmsi_res_if.sv */
interface lbmsi_res_if;
  import lbmsi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [DIR_W-1:0]        direction;
  logic [SRC_W-1:0]        source_slot;
  logic signed [TGT_W-1:0] target_slot;
  logic                    bounced;
  logic                    last;

  modport source (output valid, output direction, output source_slot, output target_slot,
                  output bounced, output last, input ready);
  modport sink (input valid, input direction, input source_slot, input target_slot,
                input bounced, input last, output ready);

endinterface

/* rtl/core/lbmsi_cell_pipe.sv */
module lbmsi_cell_pipe (
  input  logic                  clk,
  input  logic                  rst,
  input  lbmsi_pkg::cfg_t       cfg,
  lbmsi_cell_if.sink            coord,
  output logic                  req_valid,
  input  logic                  req_ready,
  output lbmsi_pkg::cell_req_t  req
);
  import lbmsi_pkg::*;

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  logic [COORD_W-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
  logic               ok1, ok2, ok3;
  logic [YZ_W-1:0]    yz2;
  logic [BASE_W-1:0]  base2, base3;
  logic [BASE_W:0]    end3;
  logic [GIDX_W-1:0]  g3;
  logic               owned3;

  // Ready chain: a stage moves when empty or when the next one moves
  assign r4 = !v4 || req_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign coord.ready = r1;
  assign req_valid = v4;

  // Ownership window [base, base + cells_per_rank)
  assign owned3 = ok3 && (BASE_W'(g3) >= base3) && ((BASE_W+1)'(g3) < end3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= coord.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3 && owned3;
    end
  end

  // Stage 1: capture and range check
  always_ff @(posedge clk) begin
    if (r1) begin
      x1  <= coord.cell_x;
      y1  <= coord.cell_y;
      z1  <= coord.cell_z;
      ok1 <= ({1'b0, coord.cell_x} < cfg.size_x) && ({1'b0, coord.cell_y} < cfg.size_y) &&
             ({1'b0, coord.cell_z} < cfg.size_z);
    end
  end

  // Stage 2: y + z*ny, and the rank base
  always_ff @(posedge clk) begin
    if (r2) begin
      x2    <= x1;
      y2    <= y1;
      z2    <= z1;
      ok2   <= ok1;
      yz2   <= YZ_W'(y1) + YZ_W'(z1) * YZ_W'(cfg.size_y);
      base2 <= BASE_W'(cfg.rank) * BASE_W'(cfg.cpr);
    end
  end

  // Stage 3: global index and end of the slice
  always_ff @(posedge clk) begin
    if (r3) begin
      x3    <= x2;
      y3    <= y2;
      z3    <= z2;
      ok3   <= ok2;
      g3    <= GIDX_W'(x2) + GIDX_W'(yz2) * GIDX_W'(cfg.size_x);
      base3 <= base2;
      end3  <= (BASE_W+1)'(base2) + (BASE_W+1)'(cfg.cpr);
    end
  end

  // Stage 4: only owned cells go on
  always_ff @(posedge clk) begin
    if (r4) begin
      req.x       <= x3;
      req.y       <= y3;
      req.z       <= z3;
      req.gidx    <= g3;
      req.base_lo <= base3[TGT_W-1:0];
    end
  end

endmodule

/* rtl/core/lbmsi_dir_seq.sv */
module lbmsi_dir_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cell_valid,
  output logic                  cell_ready,
  input  lbmsi_pkg::cell_req_t  cell_req,
  output logic                  dir_valid,
  input  logic                  dir_ready,
  output lbmsi_pkg::dir_req_t   dir_req
);
  import lbmsi_pkg::*;

  logic             busy;
  logic [DIR_W-1:0] dir;
  cell_req_t        hold;
  logic             issue_last;
  logic             load;
  logic             advance;

  assign issue_last = (dir == DIR_LAST);
  assign advance    = busy && dir_ready;
  // Next cell loads as the last direction of the current one leaves
  assign cell_ready = !busy || (issue_last && dir_ready);
  assign load       = cell_valid && cell_ready;

  assign dir_valid       = busy;
  assign dir_req.x       = hold.x;
  assign dir_req.y       = hold.y;
  assign dir_req.z       = hold.z;
  assign dir_req.gidx    = hold.gidx;
  assign dir_req.base_lo = hold.base_lo;
  assign dir_req.dir     = dir;
  assign dir_req.last    = issue_last;

  // Direction counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      dir  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      dir  <= '0;
    end else if (advance) begin
      if (issue_last) begin
        busy <= 1'b0;
      end else begin
        dir <= dir + DIR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) hold <= cell_req;
  end

endmodule

/* rtl/core/lbmsi_nbr_pipe.sv */
module lbmsi_nbr_pipe (
  input  logic                 clk,
  input  logic                 rst,
  input  lbmsi_pkg::cfg_t      cfg,
  input  logic                 dir_valid,
  output logic                 dir_ready,
  input  lbmsi_pkg::dir_req_t  dir_req,
  lbmsi_res_if.source          res
);
  import lbmsi_pkg::*;

  // Periodic wrap of a coordinate moved by at most one step
  function automatic logic [SIZE_W-1:0] wrap_step(step_t s, logic [SIZE_W-1:0] c,
                                                 logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] r;
    case (s)
      STEP_DOWN: r = (c == '0) ? n - SIZE_W'(1) : c - SIZE_W'(1);
      STEP_UP:   r = (c + SIZE_W'(1) == n) ? '0 : c + SIZE_W'(1);
      default:   r = c;
    endcase
    return r;
  endfunction

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4, r5;

  step_t             sx, sy, sz;
  logic [SIZE_W-1:0] cz;
  logic              z_out;

  logic [DIR_W-1:0]  d1, d2, d3, d4, dsel4;
  logic              last1, last2, last3, last4;
  logic              hit1, hit2, hit3, hit4;
  logic [SIZE_W-1:0] tx1, ty1, tz1, tx2;
  logic [YZ_W-1:0]   tyz2;
  logic [GIDX_W-1:0] g1, g2, g3, gn3;
  logic [TGT_W-1:0]  blo1, blo2, blo3;
  logic [TGT_W-1:0]  dt4;
  logic [SRC_W-1:0]  ds4;

  assign r5 = !res.valid || res.ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign dir_ready = r1;

  // Step of this direction and the z wall test
  assign sx = VEL_X[dir_req.dir];
  assign sy = VEL_Y[dir_req.dir];
  assign sz = VEL_Z[dir_req.dir];
  assign cz = {1'b0, dir_req.z};
  assign z_out = ((sz == STEP_DOWN) && (cz == '0)) ||
                 ((sz == STEP_UP) && (cz + SIZE_W'(1) == cfg.size_z));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (r1) v1 <= dir_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) res.valid <= v4;
    end
  end

  // Stage 1: neighbour coordinates, bounce decision
  always_ff @(posedge clk) begin
    if (r1) begin
      d1    <= dir_req.dir;
      last1 <= dir_req.last;
      tx1   <= wrap_step(sx, {1'b0, dir_req.x}, cfg.size_x);
      ty1   <= wrap_step(sy, {1'b0, dir_req.y}, cfg.size_y);
      tz1   <= wrap_step(sz, cz, cfg.size_z);
      hit1  <= z_out && cfg.walls;
      g1    <= dir_req.gidx;
      blo1  <= dir_req.base_lo;
    end
  end

  // Stage 2: ty + tz*ny
  always_ff @(posedge clk) begin
    if (r2) begin
      d2    <= d1;
      last2 <= last1;
      hit2  <= hit1;
      tx2   <= tx1;
      tyz2  <= YZ_W'(ty1) + YZ_W'(tz1) * YZ_W'(cfg.size_y);
      g2    <= g1;
      blo2  <= blo1;
    end
  end

  // Stage 3: neighbour global index
  always_ff @(posedge clk) begin
    if (r3) begin
      d3    <= d2;
      last3 <= last2;
      hit3  <= hit2;
      gn3   <= GIDX_W'(tx2) + GIDX_W'(tyz2) * GIDX_W'(cfg.size_x);
      g3    <= g2;
      blo3  <= blo2;
    end
  end

  // Stage 4: offsets from the rank base; a bounce targets its own cell
  always_ff @(posedge clk) begin
    if (r4) begin
      d4    <= d3;
      last4 <= last3;
      hit4  <= hit3;
      dsel4 <= hit3 ? OPPOSITE[d3] : d3;
      dt4   <= TGT_W'(hit3 ? g3 : gn3) - blo3;
      ds4   <= SRC_W'(g3) - blo3[SRC_W-1:0];
    end
  end

  // Stage 5: slots = 15*offset + direction, held while the sink stalls
  always_ff @(posedge clk) begin
    if (r5) begin
      res.direction   <= d4;
      res.source_slot <= (ds4 << 4) - ds4 + SRC_W'(d4);
      res.target_slot <= (dt4 << 4) - dt4 + TGT_W'(dsel4);
      res.bounced     <= hit4;
      res.last        <= last4;
    end
  end

endmodule

/* rtl/core/lbm_d3q15_stream_index_gen.sv */
// D3Q15 streaming index generator. Each accepted cell (cell_x, cell_y, cell_z)
// that lies inside the lattice and in this rank's slice of cells_per_rank global
// cells yields fifteen results, directions 0 to 14 in order, with last set on
// direction 14; other cells are dropped and yield nothing. Owned cells give one
// result per cycle while the result sink does not stall, paced by the direction
// sequencer that walks the velocity set; dropped cells never reach it, and new
// cells enter the front stages while it still walks an earlier cell. A cell's
// results pass four front stages for index and ownership, the sequencer load,
// four neighbour stages and the output register. Sizes above MAX_EXTENT act as
// MAX_EXTENT. Configuration may only be written while no request is in flight.
module lbm_d3q15_stream_index_gen #(
  parameter int MAX_EXTENT = lbmsi_pkg::MAX_EXTENT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  lbmsi_cell_if.sink                       coord,
  lbmsi_res_if.source                      res,
  input  logic                             cfg_we,
  input  logic [lbmsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbmsi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lbmsi_pkg::*;

  localparam int                EXT_CAP  = (MAX_EXTENT > (1 << SIZE_W) - 1) ?
                                           (1 << SIZE_W) - 1 : MAX_EXTENT;
  localparam logic [SIZE_W-1:0] EXT_MAX  = SIZE_W'(EXT_CAP);
  localparam logic [SIZE_W-1:0] SIZE_EFF = (SIZE_RST > EXT_MAX) ? EXT_MAX : SIZE_RST;

  cfg_t              cfg;
  logic [SIZE_W-1:0] size_wr;

  logic      cell_valid, cell_ready;
  cell_req_t cell_req;
  logic      dir_valid, dir_ready;
  dir_req_t  dir_req;

  // Sizes are stored already clamped
  assign size_wr = (cfg_data[SIZE_W-1:0] > EXT_MAX) ? EXT_MAX : cfg_data[SIZE_W-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x <= SIZE_EFF;
      cfg.size_y <= SIZE_EFF;
      cfg.size_z <= SIZE_EFF;
      cfg.walls  <= 1'b0;
      cfg.rank   <= '0;
      cfg.cpr    <= CPR_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_X: cfg.size_x <= size_wr;
        REG_SIZE_Y: cfg.size_y <= size_wr;
        REG_SIZE_Z: cfg.size_z <= size_wr;
        REG_WALLS:  cfg.walls  <= cfg_data[0];
        REG_RANK:   cfg.rank   <= cfg_data[RANK_W-1:0];
        REG_CPR:    cfg.cpr    <= cfg_data[CPR_W-1:0];
        default: ;
      endcase
    end
  end

  lbmsi_cell_pipe u_cell_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .coord     (coord),
    .req_valid (cell_valid),
    .req_ready (cell_ready),
    .req       (cell_req)
  );

  lbmsi_dir_seq u_dir_seq (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .cell_req   (cell_req),
    .dir_valid  (dir_valid),
    .dir_ready  (dir_ready),
    .dir_req    (dir_req)
  );

  lbmsi_nbr_pipe u_nbr_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .dir_valid (dir_valid),
    .dir_ready (dir_ready),
    .dir_req   (dir_req),
    .res       (res)
  );

endmodule
